FILE: design/prra_pkg.sv
// shared types and constants of the priority round-robin arbiter
package prra_pkg;

  localparam int NUM_SLOTS_DEF = 10;
  localparam int CFG_W         = 4;
  localparam int IDX_FIELD_W   = 4;
  localparam int PRIO_W        = 2;
  localparam int CTR_W         = 32;

  localparam logic KIND_REQUEST = 1'b0;
  localparam logic KIND_TICK    = 1'b1;

  typedef struct packed {
    logic                   kind;
    logic [IDX_FIELD_W-1:0] client_index;
    logic signed [7:0]      priority_value;
  } cmd_t;

  typedef struct packed {
    logic                   grant_valid;
    logic [IDX_FIELD_W-1:0] grant_client;
    logic [PRIO_W-1:0]      grant_priority;
    logic                   request_rejected;
  } result_t;

  // registered read beat from the slot store
  typedef struct packed {
    logic              valid;
    logic              pending;
    logic [PRIO_W-1:0] prio;
  } slot_rsp_t;

endpackage

FILE: design/prra_slot_store.sv
// per-slot pending flags and priority storage with one registered read port
module prra_slot_store #(
  parameter int NUM_SLOTS = prra_pkg::NUM_SLOTS_DEF,
  parameter int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  logic [IDX_W-1:0]           wr_addr,
  input  logic [prra_pkg::PRIO_W-1:0] wr_prio,
  input  logic                       clr_en,
  input  logic [IDX_W-1:0]           clr_addr,
  input  logic                       rd_en,
  input  logic [IDX_W-1:0]           rd_addr,
  output prra_pkg::slot_rsp_t        rsp
);

  logic [NUM_SLOTS-1:0]        pending;
  logic [prra_pkg::PRIO_W-1:0] prio_mem [NUM_SLOTS];

  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (wr_en) begin
        pending[wr_addr] <= 1'b1;
      end
      if (clr_en) begin
        pending[clr_addr] <= 1'b0;
      end
      rsp.valid   <= rd_en;
      rsp.pending <= pending[rd_addr];
      rsp.prio    <= prio_mem[rd_addr];
    end
  end

  // priority of an idle slot is never looked at, so it needs no clearing
  always_ff @(posedge clk) begin
    if (wr_en) begin
      prio_mem[wr_addr] <= wr_prio;
    end
  end

endmodule

FILE: design/prra_mod_unit.sv
// restoring remainder unit, one dividend bit per cycle
module prra_mod_unit #(
  parameter int R_W = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [prra_pkg::CTR_W-1:0] dividend,
  input  logic [R_W-1:0]             divisor,
  output logic                       done,
  output logic [R_W-1:0]             rem
);

  localparam int STEP_W = $clog2(prra_pkg::CTR_W);

  logic [prra_pkg::CTR_W-1:0] dvd;
  logic [STEP_W-1:0]          step;
  logic                       running;
  logic [R_W:0]               rem_sh;
  logic [R_W:0]               div_ext;
  logic [R_W-1:0]             rem_next;

  assign rem_sh  = {rem, dvd[prra_pkg::CTR_W-1]};
  assign div_ext = {1'b0, divisor};

  always_comb begin
    if (rem_sh >= div_ext) begin
      rem_next = R_W'(rem_sh - div_ext);
    end else begin
      rem_next = R_W'(rem_sh);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        step    <= '0;
        dvd     <= dividend;
        rem     <= '0;
      end else if (running) begin
        rem  <= rem_next;
        dvd  <= dvd << 1;
        step <= step + 1'b1;
        if (step == STEP_W'(prra_pkg::CTR_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: design/priority_round_robin_arbiter_top.sv
// priority arbiter with round-robin tie-break: sequencer and top level
// a request beat is handled in IDLE; its result strobes on the cycle after start
// a tick scans one slot per cycle over slots 0 to n-1, with n = min(active_clients, slots)
// a tie adds a remainder pass (32 steps, then done) and a second scan that picks among the tied slots
// busy stays high while a tick runs; results cannot be stalled by the receiver
// reset idles every slot and clears the tie counter and active_clients
module priority_round_robin_arbiter_top #(
  parameter int NUM_SLOTS = prra_pkg::NUM_SLOTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  prra_pkg::cmd_t             cmd,
  output logic                       done,
  output prra_pkg::result_t          result,
  input  logic                       cfg_wr_en,
  input  logic [prra_pkg::CFG_W-1:0] cfg_wr_data
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);

  typedef enum logic [1:0] {IDLE, SCAN, MOD, PICK} state_t;

  state_t                      state;
  logic [prra_pkg::CFG_W-1:0]  active_clients;
  logic [prra_pkg::CTR_W-1:0]  tie_counter;
  logic [CNT_W-1:0]            n;
  logic [CNT_W-1:0]            scan_idx;
  logic [IDX_W-1:0]            rd_idx_q;
  logic                        any;
  logic [prra_pkg::PRIO_W-1:0] best;
  logic [CNT_W-1:0]            ties;
  logic [IDX_W-1:0]            pick;
  logic [CNT_W-1:0]            skip;
  logic                        found;

  prra_pkg::slot_rsp_t         rsp;
  logic                        req_bad;
  logic                        wr_en;
  logic                        rd_en;
  logic                        clr_en;
  logic                        scan_done;
  logic                        mod_start;
  logic                        mod_done;
  logic [CNT_W-1:0]            mod_rem;
  logic [CNT_W-1:0]            n_clamp;

  assign busy = (state != IDLE);

  assign req_bad = (cmd.priority_value[7:2] != 6'd0) ||
                   ({4'd0, cmd.client_index} >= 8'(NUM_SLOTS));
  assign wr_en   = (state == IDLE) && start && (cmd.kind == prra_pkg::KIND_REQUEST) &&
                   !req_bad;

  assign n_clamp = ({4'd0, active_clients} > 8'(NUM_SLOTS)) ? CNT_W'(NUM_SLOTS)
                                                             : CNT_W'(active_clients);

  assign rd_en     = ((state == SCAN) || (state == PICK)) && (scan_idx < n);
  // the last read beat has been consumed once no beat is in flight
  assign scan_done = (scan_idx == n) && !rsp.valid;
  assign mod_start = (state == SCAN) && scan_done && any && (ties != CNT_W'(1));
  assign clr_en    = scan_done &&
                     (((state == SCAN) && any && (ties == CNT_W'(1))) || (state == PICK));

  prra_slot_store #(
    .NUM_SLOTS (NUM_SLOTS),
    .IDX_W     (IDX_W)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_addr  (IDX_W'(cmd.client_index)),
    .wr_prio  (cmd.priority_value[prra_pkg::PRIO_W-1:0]),
    .clr_en   (clr_en),
    .clr_addr (pick),
    .rd_en    (rd_en),
    .rd_addr  (scan_idx[IDX_W-1:0]),
    .rsp      (rsp)
  );

  prra_mod_unit #(
    .R_W (CNT_W)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (tie_counter),
    .divisor  (ties),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_idx_q <= scan_idx[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= IDLE;
      done           <= 1'b0;
      active_clients <= '0;
      tie_counter    <= '0;
    end else begin
      done <= 1'b0;
      if (cfg_wr_en) begin
        active_clients <= cfg_wr_data;
      end
      case (state)
        IDLE: begin
          if (start) begin
            if (cmd.kind == prra_pkg::KIND_TICK) begin
              n        <= n_clamp;
              scan_idx <= '0;
              any      <= 1'b0;
              best     <= '0;
              ties     <= '0;
              pick     <= '0;
              state    <= SCAN;
            end else begin
              result.grant_valid      <= 1'b0;
              result.grant_client     <= '0;
              result.grant_priority   <= '0;
              result.request_rejected <= req_bad;
              done                    <= 1'b1;
            end
          end
        end
        SCAN: begin
          if (scan_idx < n) begin
            scan_idx <= scan_idx + 1'b1;
          end
          if (rsp.valid && rsp.pending) begin
            if (!any || (rsp.prio > best)) begin
              any  <= 1'b1;
              best <= rsp.prio;
              ties <= CNT_W'(1);
              pick <= rd_idx_q;
            end else if (rsp.prio == best) begin
              ties <= ties + 1'b1;
            end
          end
          if (scan_done) begin
            if (!any) begin
              result <= '0;
              done   <= 1'b1;
              state  <= IDLE;
            end else if (ties == CNT_W'(1)) begin
              result.grant_valid      <= 1'b1;
              result.grant_client     <= prra_pkg::IDX_FIELD_W'(pick);
              result.grant_priority   <= best;
              result.request_rejected <= 1'b0;
              done                    <= 1'b1;
              state                   <= IDLE;
            end else begin
              state <= MOD;
            end
          end
        end
        MOD: begin
          if (mod_done) begin
            skip     <= mod_rem;
            scan_idx <= '0;
            found    <= 1'b0;
            state    <= PICK;
          end
        end
        PICK: begin
          if (scan_idx < n) begin
            scan_idx <= scan_idx + 1'b1;
          end
          // walk the tied slots in index order, skipping by the remainder
          if (rsp.valid && rsp.pending && (rsp.prio == best) && !found) begin
            if (skip == '0) begin
              found <= 1'b1;
              pick  <= rd_idx_q;
            end else begin
              skip <= skip - 1'b1;
            end
          end
          if (scan_done) begin
            result.grant_valid      <= 1'b1;
            result.grant_client     <= prra_pkg::IDX_FIELD_W'(pick);
            result.grant_priority   <= best;
            result.request_rejected <= 1'b0;
            done                    <= 1'b1;
            tie_counter             <= tie_counter + 1'b1;
            state                   <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule
